/* src/bitmap_pool_slot_allocator_macros.svh */
// Assertion macros shared by the slot allocator RTL.
`ifndef BITMAP_POOL_SLOT_ALLOCATOR_MACROS_SVH
`define BITMAP_POOL_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, held off during reset.
`define BPSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define BPSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bpsa_pkg.sv */
// Types, constants and helper functions of the slot allocator.
package bpsa_pkg;

  localparam int POOL_SLOTS = 64;   // power of two, 8..64
  localparam int POOLS      = 16;   // 1..2**(IDX_W-POS_W), 16 here
  localparam int IDX_W      = 10;
  localparam int POS_W      = $clog2(POOL_SLOTS);
  localparam int POOL_AW    = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int CNT_W      = $clog2(POOLS + 1);

  typedef logic [POOL_SLOTS-1:0] mask_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [POOL_AW-1:0]    pool_idx_t;
  typedef logic [CNT_W-1:0]      pool_cnt_t;
  typedef logic [POOLS-1:0]      pool_vec_t;
  typedef logic [IDX_W-1:0]      slot_idx_t;

  localparam mask_t FULL_MASK = '1;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_QUERY = 2'd1,
    OP_MARK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    op_t       op;
    slot_idx_t slot_index;
  } bpsa_in_t;

  typedef struct packed {
    slot_idx_t granted_slot;
    logic      slot_used;
    logic      out_of_slots;
  } bpsa_out_t;

  // Pool bookkeeping seen by the controller.
  typedef struct packed {
    logic      hit;         // some opened pool still has a free slot
    pool_idx_t hit_pool;    // highest such pool
    logic      all_open;    // no pool left to open
    pool_idx_t next_pool;   // pool that the next open takes
    pool_cnt_t opened;
    pool_vec_t fresh;       // pool reads as all free regardless of RAM
  } sum_status_t;

  // Bookkeeping update from the controller's write-back.
  typedef struct packed {
    logic      wr;
    pool_idx_t pool;
    logic      nonempty;
    logic      open;
    logic      clear_all;
  } sum_upd_t;

  function automatic pos_t lowest_set(mask_t m);
    pos_t r;
    r = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = pos_t'(i);
      end
    end
    return r;
  endfunction

  function automatic slot_idx_t slot_of(pool_idx_t p, pos_t b);
    logic [31:0] t;
    t = (32'(p) << POS_W) | 32'(b);
    return t[IDX_W-1:0];
  endfunction

endpackage

/* src/bpsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bpsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/bpsa_summary.sv */
// Per-pool nonempty/fresh bits, open-pool count and pool selection.
`include "bitmap_pool_slot_allocator_macros.svh"

module bpsa_summary (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bpsa_pkg::sum_upd_t   upd,
  output bpsa_pkg::sum_status_t status
);
  import bpsa_pkg::*;

  pool_vec_t nonempty_r, nonempty_nxt;
  pool_vec_t fresh_r, fresh_nxt;
  pool_cnt_t opened_r, opened_nxt;

  always_comb begin
    nonempty_nxt = nonempty_r;
    fresh_nxt    = fresh_r;
    opened_nxt   = opened_r;
    if (upd.clear_all) begin
      nonempty_nxt = '1;
      fresh_nxt    = '1;
    end
    if (upd.wr) begin
      nonempty_nxt[upd.pool] = upd.nonempty;
      fresh_nxt[upd.pool]    = 1'b0;
    end
    if (upd.open) begin
      opened_nxt = opened_r + pool_cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r <= '1;
      fresh_r    <= '1;
      opened_r   <= '0;
    end else begin
      nonempty_r <= nonempty_nxt;
      fresh_r    <= fresh_nxt;
      opened_r   <= opened_nxt;
    end
  end

  // highest opened pool with a free slot
  always_comb begin
    status.hit      = 1'b0;
    status.hit_pool = '0;
    for (int p = 0; p < POOLS; p++) begin
      if (nonempty_r[p] && (pool_cnt_t'(p) < opened_r)) begin
        status.hit      = 1'b1;
        status.hit_pool = pool_idx_t'(p);
      end
    end
    status.all_open  = (opened_r == pool_cnt_t'(POOLS));
    status.next_pool = opened_r[POOL_AW-1:0];
    status.opened    = opened_r;
    status.fresh     = fresh_r;
  end

  `BPSA_ASSERT_NOW(a_opened_bound, clk, rst_n, 1'b1, opened_r <= pool_cnt_t'(POOLS), "open count beyond pool count")
  `BPSA_ASSERT_NOW(a_no_open_when_full, clk, rst_n, upd.open, opened_r < pool_cnt_t'(POOLS), "pool opened with none left")
  `BPSA_ASSERT_NOW(a_clear_no_write, clk, rst_n, upd.clear_all, !upd.wr, "free all with a write")

endmodule

/* src/bitmap_pool_slot_allocator.sv */
// Top level of the bitmap pool slot allocator: controller and mask datapath.
`include "bitmap_pool_slot_allocator_macros.svh"

// Bitmap pool slot allocator. Each request (allocate, query, mark used,
// free all) is accepted at a clock edge with start high and busy low:
// the accept edge reads the chosen pool's free mask from the registered
// mask RAM, and the following execute cycle modifies it and writes it
// back, so busy is high for exactly one cycle after each accept and no new
// request is taken until the execute cycle is over. The result appears on
// out_res with out_strobe high for exactly one cycle, the cycle right
// after the execute cycle, registered at the end of it; it is not held,
// and the receiver cannot stall it. Every request yields exactly one
// result. Pool choice for allocate comes from per-pool nonempty flags
// kept in flops, so no search over the RAM is needed. Free-all marks
// pools fresh in flops instead of sweeping the RAM, so it takes no longer
// than other requests and there is no clearing pass after reset. A slot in
// a pool not yet opened reads as unused, and marking it does nothing.
module bitmap_pool_slot_allocator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bpsa_pkg::bpsa_in_t  in_req,
  output logic                out_strobe,
  output bpsa_pkg::bpsa_out_t out_res
);
  import bpsa_pkg::*;

  state_t    state_r, state_nxt;
  logic      accept;

  // request latched at accept
  op_t       op_r;
  pool_idx_t pool_r;
  pos_t      pos_r;
  logic      opened_r;
  logic      hit_r;
  logic      all_open_r;

  // result register
  logic      out_strobe_r, out_strobe_nxt;
  bpsa_out_t out_res_r, out_res_nxt;

  // RAM and bookkeeping
  sum_status_t status;
  sum_upd_t    upd;
  logic        ram_we;
  mask_t       ram_wdata;
  mask_t       ram_rdata;
  pool_idx_t   ram_raddr;
  mask_t       cur_mask;
  mask_t       new_mask;
  pos_t        low_bit;

  // decode of the incoming request
  logic [IDX_W-1:0] req_pool;
  logic             req_opened;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign req_pool   = in_req.slot_index >> POS_W;
  assign req_opened = (req_pool < IDX_W'(status.opened));
  assign ram_raddr  = (in_req.op == OP_ALLOC) ? status.hit_pool : req_pool[POOL_AW-1:0];

  bpsa_summary u_summary (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (upd),
    .status (status)
  );

  bpsa_ram #(
    .WIDTH (POOL_SLOTS),
    .DEPTH (POOLS)
  ) u_mask_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pool_r),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_req.op;
      pos_r      <= in_req.slot_index[POS_W-1:0];
      opened_r   <= req_opened;
      hit_r      <= status.hit;
      all_open_r <= status.all_open;
      if (in_req.op == OP_ALLOC) begin
        pool_r <= status.hit ? status.hit_pool : status.next_pool;
      end else begin
        pool_r <= req_pool[POOL_AW-1:0];
      end
    end
  end

  // fresh pools read as all free; the RAM entry may be stale or unwritten
  assign cur_mask = status.fresh[pool_r] ? FULL_MASK : ram_rdata;
  assign low_bit  = lowest_set(cur_mask);

  always_comb begin
    state_nxt      = state_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = '0;
    ram_we         = 1'b0;
    new_mask       = cur_mask;
    upd            = '0;
    upd.pool       = pool_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt      = ST_IDLE;
        out_strobe_nxt = 1'b1;
        case (op_r)
          OP_ALLOC: begin
            if (hit_r) begin
              new_mask                 = cur_mask & ~(mask_t'(1) << low_bit);
              ram_we                   = 1'b1;
              out_res_nxt.granted_slot = slot_of(pool_r, low_bit);
            end else if (!all_open_r) begin
              // open the next pool and hand out its slot 0
              new_mask                 = FULL_MASK & ~mask_t'(1);
              ram_we                   = 1'b1;
              upd.open                 = 1'b1;
              out_res_nxt.granted_slot = slot_of(pool_r, '0);
            end else begin
              out_res_nxt.out_of_slots = 1'b1;
            end
          end
          OP_QUERY: begin
            out_res_nxt.slot_used = opened_r && !cur_mask[pos_r];
          end
          OP_MARK: begin
            if (opened_r) begin
              new_mask = cur_mask & ~(mask_t'(1) << pos_r);
              ram_we   = 1'b1;
            end
          end
          OP_CLEAR: begin
            upd.clear_all = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    ram_wdata    = new_mask;
    upd.wr       = ram_we;
    upd.nonempty = |new_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  `BPSA_ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, busy && !out_strobe, "accept not followed by execute cycle")
  `BPSA_ASSERT_NEXT(a_exec_result, clk, rst_n, busy, out_strobe && !busy, "execute cycle gave no single result")
  `BPSA_ASSERT_NOW(a_oos_no_grant, clk, rst_n, out_strobe && out_res.out_of_slots, out_res.granted_slot == '0, "grant with out of slots")

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the bitmap pool slot allocator.
module testbench;
  import bpsa_pkg::*;

  // Longest sender gap, in cycles.
  localparam int GAP_MAX       = 11;
  // Cycles with neither an accepted request nor a result before the run is abandoned.
  localparam int IDLE_LIMIT    = 200;
  // Extra wait at the end, past the last result.
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_PRINTED   = 100;

  // One directed step. The expected fields are used only when chk is set;
  // otherwise the allocator model decides.
  typedef struct packed {
    op_t       op;
    slot_idx_t idx;
    logic      chk;
    slot_idx_t g;
    logic      u;
    logic      o;
  } dir_row_t;

  localparam int N_DIR = 21;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{OP_QUERY, 10'd0,    1'b1, 10'd0, 1'b0, 1'b0},  // nothing open yet
    '{OP_MARK,  10'd5,    1'b1, 10'd0, 1'b0, 1'b0},  // unopened pool: ignored
    '{OP_ALLOC, 10'd0,    1'b1, 10'd0, 1'b0, 1'b0},  // opens pool 0
    '{OP_QUERY, 10'd0,    1'b1, 10'd0, 1'b1, 1'b0},
    '{OP_QUERY, 10'd5,    1'b1, 10'd0, 1'b0, 1'b0},  // earlier mark had no effect
    '{OP_MARK,  10'd1,    1'b1, 10'd0, 1'b0, 1'b0},
    '{OP_ALLOC, 10'd0,    1'b1, 10'd2, 1'b0, 1'b0},  // skips the marked slot
    '{OP_MARK,  10'd63,   1'b1, 10'd0, 1'b0, 1'b0},  // top of pool 0
    '{OP_QUERY, 10'd63,   1'b1, 10'd0, 1'b1, 1'b0},
    '{OP_QUERY, 10'd1023, 1'b1, 10'd0, 1'b0, 1'b0},  // last slot, unopened pool
    '{OP_QUERY, 10'd64,   1'b1, 10'd0, 1'b0, 1'b0},
    '{OP_ALLOC, 10'd1023, 1'b0, 10'd0, 1'b0, 1'b0},  // index is don't-care here
    '{OP_CLEAR, 10'd0,    1'b1, 10'd0, 1'b0, 1'b0},
    '{OP_QUERY, 10'd0,    1'b1, 10'd0, 1'b0, 1'b0},  // pool stays open, all free
    '{OP_ALLOC, 10'd0,    1'b1, 10'd0, 1'b0, 1'b0},
    '{OP_ALLOC, 10'd682,  1'b1, 10'd1, 1'b0, 1'b0},
    '{OP_MARK,  10'd1023, 1'b1, 10'd0, 1'b0, 1'b0},
    '{OP_QUERY, 10'd341,  1'b0, 10'd0, 1'b0, 1'b0},
    '{OP_MARK,  10'd2,    1'b0, 10'd0, 1'b0, 1'b0},
    '{OP_ALLOC, 10'd0,    1'b0, 10'd0, 1'b0, 1'b0},
    '{OP_QUERY, 10'd2,    1'b0, 10'd0, 1'b0, 1'b0}
  };

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  bpsa_in_t  in_req;
  logic      out_strobe;
  bpsa_out_t out_res;

  // Typed-in expectation that travels with the request being offered.
  logic      lit_chk;
  bpsa_out_t lit_res;

  // Allocator model state.
  mask_t     free_map [POOLS];
  int        open_pools;
  bpsa_out_t pending_q [$];

  bit burst;            // when set the sender offers requests back to back
  int errors      = 0;
  int idle_cycles = 0;
  int n_req       = 0;
  int n_grant     = 0;
  int n_oos       = 0;
  int n_used_hit  = 0;
  int top_grant   = 0;

  bitmap_pool_slot_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
  endtask

  // Applies one request to the allocator model and returns its result.
  function automatic bpsa_out_t predict_slot_op(bpsa_in_t r);
    bpsa_out_t res;
    int        pool;
    int        pos;
    int        p;
    int        b;
    bit        opened;
    res    = '0;
    pool   = int'(r.slot_index) / POOL_SLOTS;
    pos    = int'(r.slot_index) % POOL_SLOTS;
    opened = (pool < open_pools) && (pool < POOLS);
    case (r.op)
      OP_ALLOC: begin
        // Newest opened pool first, lowest free slot within it.
        b = -1;
        p = open_pools;
        while (p > 0 && b < 0) begin
          p--;
          if (p < POOLS) begin
            for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
              if (free_map[p][i]) b = i;
            end
          end
        end
        if (b >= 0) begin
          free_map[p][b]   = 1'b0;
          res.granted_slot = slot_idx_t'(p * POOL_SLOTS + b);
        end else if (open_pools < POOLS) begin
          // Nothing free: open the next pool and hand out its slot 0.
          free_map[open_pools]    = '1;
          free_map[open_pools][0] = 1'b0;
          res.granted_slot        = slot_idx_t'(open_pools * POOL_SLOTS);
          open_pools++;
        end else begin
          res.out_of_slots = 1'b1;
        end
      end
      OP_QUERY: begin
        if (opened) res.slot_used = ~free_map[pool][pos];
      end
      OP_MARK: begin
        if (opened) free_map[pool][pos] = 1'b0;
      end
      default: begin
        // Free all: pools stay open.
        for (p = 0; p < open_pools && p < POOLS; p++) free_map[p] = '1;
      end
    endcase
    return res;
  endfunction

  // Result check, then request capture. Both see the values from before
  // the edge; a result can never belong to a request accepted at the same
  // edge, so the order of the two is safe either way.
  always @(posedge clk) begin
    bpsa_out_t want;
    if (rst_n) begin
      if (out_strobe === 1'b1) begin
        if (pending_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = pending_q.pop_front();
          if (out_res.granted_slot !== want.granted_slot)
            report_mismatch($sformatf("granted_slot %0d, expected %0d",
                                      out_res.granted_slot, want.granted_slot));
          if (out_res.slot_used !== want.slot_used)
            report_mismatch($sformatf("slot_used %0b, expected %0b",
                                      out_res.slot_used, want.slot_used));
          if (out_res.out_of_slots !== want.out_of_slots)
            report_mismatch($sformatf("out_of_slots %0b, expected %0b",
                                      out_res.out_of_slots, want.out_of_slots));
        end
      end
      if (start && busy === 1'b0) begin
        want = predict_slot_op(in_req);
        n_req++;
        if (in_req.op == OP_ALLOC && !want.out_of_slots) begin
          n_grant++;
          if (int'(want.granted_slot) > top_grant) top_grant = int'(want.granted_slot);
        end
        if (want.out_of_slots) n_oos++;
        if (want.slot_used) n_used_hit++;
        if (lit_chk) want = lit_res;
        pending_q.push_back(want);
      end
    end
  end

  // Watchdog on cycles where nothing moves in either direction.
  always @(posedge clk) begin
    if (!rst_n || out_strobe === 1'b1 || (start && busy === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_q.size());
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one request. Entered and left at a falling edge; start is left
  // high so a back-to-back request needs no second assignment in a step.
  task automatic issue(bpsa_in_t r, logic chk, bpsa_out_t lit);
    int gap;
    gap = burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_req  <= r;
    lit_chk <= chk;
    lit_res <= lit;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // Holds the sender off until every result is back.
  task automatic wait_for_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  // Mixed traffic; most indexes land in opened pools so queries and marks
  // actually touch live masks.
  task automatic random_phase(int count);
    bpsa_in_t r;
    int       pick;
    repeat (count) begin
      if ($urandom_range(0, 29) == 0) burst = ~burst;
      pick = $urandom_range(0, 99);
      r.op = (pick < 45) ? OP_ALLOC :
             (pick < 70) ? OP_QUERY :
             (pick < 97) ? OP_MARK  : OP_CLEAR;
      if (open_pools > 0 && $urandom_range(0, 4) != 0)
        r.slot_index = slot_idx_t'($urandom_range(0, open_pools * POOL_SLOTS - 1));
      else
        r.slot_index = slot_idx_t'($urandom_range(0, 2 ** IDX_W - 1));
      issue(r, 1'b0, '0);
    end
  endtask

  // Allocations, marks and queries with no free-all until every pool is open
  // and full, then more until oos_wanted allocations have reported exhaustion.
  task automatic fill_phase(int oos_wanted);
    bpsa_in_t r;
    int       pick;
    int       oos_goal;
    oos_goal = n_oos + oos_wanted;
    while (n_oos < oos_goal) begin
      if ($urandom_range(0, 29) == 0) burst = ~burst;
      pick = $urandom_range(0, 99);
      r.op = (pick < 85) ? OP_ALLOC : (pick < 97) ? OP_MARK : OP_QUERY;
      if (open_pools > 0)
        r.slot_index = slot_idx_t'($urandom_range(0, open_pools * POOL_SLOTS - 1));
      else
        r.slot_index = slot_idx_t'($urandom_range(0, 2 ** IDX_W - 1));
      issue(r, 1'b0, '0);
    end
  endtask

  initial begin
    bpsa_in_t  r;
    bpsa_out_t lit;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_req  = '0;
    lit_chk = 1'b0;
    lit_res = '0;
    burst   = 1'b0;
    for (int p = 0; p < POOLS; p++) free_map[p] = '1;
    open_pools = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed steps.
    for (int i = 0; i < N_DIR; i++) begin
      r.op             = DIR_TAB[i].op;
      r.slot_index     = DIR_TAB[i].idx;
      lit.granted_slot = DIR_TAB[i].g;
      lit.slot_used    = DIR_TAB[i].u;
      lit.out_of_slots = DIR_TAB[i].o;
      issue(r, DIR_TAB[i].chk, lit);
    end
    wait_for_results();

    burst = 1'b1;
    random_phase(80);
    burst = 1'b0;
    random_phase(80);
    wait_for_results();

    fill_phase(4);
    wait_for_results();
    random_phase(60);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("run: %0d requests, %0d slots granted (highest %0d), %0d exhausted allocations",
             n_req, n_grant, top_grant, n_oos);
    $display("run: %0d queries found a used slot, %0d pools open at the end",
             n_used_hit, open_pools);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
